@@ rtl/kpsdb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpsdb_pkg
// Shared types, constants and key position tables for the keypad scanner.
// ----------------------------------------------------------------------------
package kpsdb_pkg;

    localparam int unsigned KEY_POSITIONS = 13;
    localparam int unsigned POS_W         = 4;
    localparam int unsigned ROWS_W        = 4;
    localparam int unsigned COLS_W        = 4;
    localparam int unsigned CODE_W        = 4;
    localparam int unsigned CNT_W         = 8;
    localparam int unsigned CFG_DATA_W    = 8;
    localparam int unsigned CFG_INDEX_W   = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TICKS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BEEP_TOGGLES   = 1'd1;

    localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd20;
    localparam logic [CNT_W-1:0] BEEP_RESET     = 8'd100;

    typedef enum logic [4:0] {
        PH_SCAN    = 5'b00001,
        PH_DEB1    = 5'b00010,
        PH_RELEASE = 5'b00100,
        PH_DEB2    = 5'b01000,
        PH_BEEP    = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [CNT_W-1:0] debounce_ticks;
        logic [CNT_W-1:0] beep_toggles;
    } cfg_t;

    typedef struct packed {
        logic [COLS_W-1:0] column_drive;
        logic              buzzer_out;
        logic              key_valid;
        logic [CODE_W-1:0] key_code;
    } result_t;

    // key code per scan position
    function automatic logic [CODE_W-1:0] pos_code(input logic [POS_W-1:0] pos);
        logic [CODE_W-1:0] code;
        case (pos)
            4'd0:    code = 4'd1;
            4'd1:    code = 4'd4;
            4'd2:    code = 4'd7;
            4'd3:    code = 4'd2;
            4'd4:    code = 4'd5;
            4'd5:    code = 4'd8;
            4'd6:    code = 4'd0;
            4'd7:    code = 4'd3;
            4'd8:    code = 4'd6;
            4'd9:    code = 4'd9;
            4'd10:   code = 4'd11;
            4'd11:   code = 4'd12;
            4'd12:   code = 4'd13;
            default: code = 4'd1;
        endcase
        return code;
    endfunction

    // bit of row_levels tested at each position (bit3 = row 7)
    function automatic logic [1:0] pos_row_bit(input logic [POS_W-1:0] pos);
        logic [1:0] rb;
        case (pos)
            4'd0, 4'd3, 4'd7, 4'd10: rb = 2'd3;
            4'd1, 4'd4, 4'd8, 4'd11: rb = 2'd2;
            4'd2, 4'd5, 4'd9, 4'd12: rb = 2'd1;
            4'd6:                    rb = 2'd0;
            default:                 rb = 2'd3;
        endcase
        return rb;
    endfunction

    // active-low column drive pattern at each position
    function automatic logic [COLS_W-1:0] pos_column_drive(input logic [POS_W-1:0] pos);
        logic [COLS_W-1:0] pat;
        case (pos)
            4'd0, 4'd1, 4'd2:        pat = 4'b0111;
            4'd3, 4'd4, 4'd5, 4'd6:  pat = 4'b1011;
            4'd7, 4'd8, 4'd9:        pat = 4'b1101;
            4'd10, 4'd11, 4'd12:     pat = 4'b1110;
            default:                 pat = 4'b0111;
        endcase
        return pat;
    endfunction

endpackage : kpsdb_pkg
`default_nettype wire

@@ rtl/kpsdb_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpsdb_tick_if / kpsdb_result_if
// Valid/ready channels for scan ticks and scan results.
// ----------------------------------------------------------------------------
interface kpsdb_tick_if;
    logic       valid;
    logic       ready;
    logic [3:0] row_levels;

    modport source (output valid, output row_levels, input ready);
    modport sink   (input valid, input row_levels, output ready);
endinterface : kpsdb_tick_if

interface kpsdb_result_if;
    logic       valid;
    logic       ready;
    logic [3:0] column_drive;
    logic       buzzer_out;
    logic       key_valid;
    logic [3:0] key_code;

    modport source (output valid, output column_drive, output buzzer_out,
                    output key_valid, output key_code, input ready);
    modport sink   (input valid, input column_drive, input buzzer_out,
                    input key_valid, input key_code, output ready);
endinterface : kpsdb_result_if
`default_nettype wire

@@ rtl/kpsdb_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpsdb_cfg_regs
// Debounce and beep length registers behind a plain write port.
// ----------------------------------------------------------------------------
module kpsdb_cfg_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [kpsdb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [kpsdb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output kpsdb_pkg::cfg_t                        cfg
);
    import kpsdb_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_DEBOUNCE_TICKS: cfg_next.debounce_ticks = cfg_wdata;
                REG_BEEP_TOGGLES:   cfg_next.beep_toggles   = cfg_wdata;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks <= DEBOUNCE_RESET;
            cfg_reg.beep_toggles   <= BEEP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule : kpsdb_cfg_regs
`default_nettype wire

@@ rtl/kpsdb_scan_fsm.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpsdb_scan_fsm
// Per-tick scan, debounce, release and beep sequencing; one step per tick.
// ----------------------------------------------------------------------------
module kpsdb_scan_fsm (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         step,
    input  wire logic [kpsdb_pkg::ROWS_W-1:0] row_levels,
    input  wire kpsdb_pkg::cfg_t              cfg,
    output kpsdb_pkg::result_t                result
);
    import kpsdb_pkg::*;

    phase_t            phase_reg,  phase_next;
    logic [POS_W-1:0]  pos_reg,    pos_next;
    logic [CNT_W-1:0]  wait_reg,   wait_next;
    logic [CNT_W-1:0]  toggle_reg, toggle_next;
    logic              buzz_reg,   buzz_next;
    logic [CODE_W-1:0] held_reg,   held_next;

    logic [POS_W-1:0]  pos_safe;
    logic [POS_W-1:0]  pos_adv;
    logic              row_low;
    logic              done;

    always_comb
    begin
        pos_safe = (pos_reg < POS_W'(KEY_POSITIONS)) ? pos_reg : '0;
        pos_adv  = (pos_safe == POS_W'(KEY_POSITIONS - 1)) ? '0 : pos_safe + 1'b1;
        row_low  = ~row_levels[pos_row_bit(pos_safe)];

        phase_next  = phase_reg;
        pos_next    = pos_reg;
        wait_next   = wait_reg;
        toggle_next = toggle_reg;
        buzz_next   = buzz_reg;
        held_next   = held_reg;
        done        = 1'b0;

        case (phase_reg)
            PH_SCAN:
            begin
                if (row_low)
                begin
                    held_next  = pos_code(pos_safe);
                    wait_next  = cfg.debounce_ticks;
                    phase_next = PH_DEB1;
                end
                else
                begin
                    pos_next = pos_adv;
                end
            end
            PH_DEB1:
            begin
                if (wait_reg <= 8'd1)
                begin
                    wait_next  = '0;
                    phase_next = PH_RELEASE;
                end
                else
                begin
                    wait_next = wait_reg - 8'd1;
                end
            end
            PH_RELEASE:
            begin
                // release tick reloads but is not counted
                if (!row_low)
                begin
                    wait_next  = cfg.debounce_ticks;
                    phase_next = PH_DEB2;
                end
            end
            PH_DEB2:
            begin
                if (wait_reg <= 8'd1)
                begin
                    wait_next = '0;
                    if (cfg.beep_toggles == '0)
                    begin
                        done       = 1'b1;
                        pos_next   = pos_adv;
                        phase_next = PH_SCAN;
                    end
                    else
                    begin
                        toggle_next = cfg.beep_toggles;
                        phase_next  = PH_BEEP;
                    end
                end
                else
                begin
                    wait_next = wait_reg - 8'd1;
                end
            end
            PH_BEEP:
            begin
                buzz_next = ~buzz_reg;
                if (toggle_reg <= 8'd1)
                begin
                    toggle_next = '0;
                    done        = 1'b1;
                    pos_next    = pos_adv;
                    phase_next  = PH_SCAN;
                end
                else
                begin
                    toggle_next = toggle_reg - 8'd1;
                end
            end
            default:
            begin
                phase_next = PH_SCAN;
            end
        endcase

        result.column_drive = pos_column_drive(pos_next);
        result.buzzer_out   = buzz_next;
        result.key_valid    = done;
        result.key_code     = done ? held_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SCAN;
            pos_reg    <= '0;
            wait_reg   <= '0;
            toggle_reg <= '0;
            buzz_reg   <= 1'b1;
            held_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            wait_reg   <= wait_next;
            toggle_reg <= toggle_next;
            buzz_reg   <= buzz_next;
            held_reg   <= held_next;
        end
    end

endmodule : kpsdb_scan_fsm
`default_nettype wire

@@ rtl/kpsdb_out_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpsdb_out_stage
// Result register; takes a new result when it is empty or when the held one is leaving.
// ----------------------------------------------------------------------------
module kpsdb_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire kpsdb_pkg::result_t result,
    output logic                   can_load,
    kpsdb_result_if.source         out_ch
);
    import kpsdb_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign can_load   = !valid_reg || out_ch.ready;
    assign valid_next = load || (valid_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out_ch.valid        = valid_reg;
    assign out_ch.column_drive = data_reg.column_drive;
    assign out_ch.buzzer_out   = data_reg.buzzer_out;
    assign out_ch.key_valid    = data_reg.key_valid;
    assign out_ch.key_code     = data_reg.key_code;

endmodule : kpsdb_out_stage
`default_nettype wire

@@ rtl/keypad_scan_debounce_beep_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Output: each accepted tick's result is registered in the result register before it is presented.
// Throughput: 1 tick per cycle; ready drops only while a result is held
// and the result channel is stalled.
// Reset: scanning from column 0 row 7, buzzer high, debounce 20, beep 100,
// result register empty.
// ----------------------------------------------------------------------------
// keypad_scan_debounce_beep_top
// 4x4 keypad scanner with debounce and key-click buzzer, one tick per step.
// ----------------------------------------------------------------------------
module keypad_scan_debounce_beep_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [kpsdb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [kpsdb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    kpsdb_tick_if.sink                             tick,
    kpsdb_result_if.source                         result
);
    import kpsdb_pkg::*;

    cfg_t    cfg;
    result_t step_result;
    logic    can_load;
    logic    step;

    assign tick.ready = can_load;
    assign step       = tick.valid && can_load;

    kpsdb_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    kpsdb_scan_fsm u_scan_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .row_levels (tick.row_levels),
        .cfg        (cfg),
        .result     (step_result)
    );

    kpsdb_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step),
        .result   (step_result),
        .can_load (can_load),
        .out_ch   (result)
    );

endmodule : keypad_scan_debounce_beep_top
`default_nettype wire
